FILE: rtl/core/mis_pkg.sv
`timescale 1ns / 1ps
package mis_pkg;

  // Item commands
  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_MANUAL = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_UNUSED = 2'd3
  } mis_cmd_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_RUN_TENTHS = 2'd1,
    REG_WEEK_MIN  = 2'd2,
    REG_WEEK_MAX  = 2'd3
  } mis_reg_e;

  // Timing constants
  localparam int unsigned TicksPerSecond = 10;
  localparam int unsigned CheckPeriodS   = 14400;
  localparam int unsigned SensorDelayS   = 2;
  localparam int unsigned LockSeconds    = 14400;

  localparam int unsigned PhaseW  = $clog2(TicksPerSecond + 1);
  localparam int unsigned WaitW   = $clog2(SensorDelayS * TicksPerSecond + 1);
  localparam int unsigned CheckW  = $clog2(CheckPeriodS + 1);
  localparam int unsigned LockW   = $clog2(LockSeconds + 1);

  localparam logic [PhaseW-1:0] PHASE_LAST = PhaseW'(TicksPerSecond - 1);
  localparam logic [WaitW-1:0]  WAIT_LOAD  = WaitW'(SensorDelayS * TicksPerSecond);
  localparam logic [CheckW-1:0] CHECK_END  = CheckW'(CheckPeriodS);
  localparam logic [LockW-1:0]  LOCK_END   = LockW'(LockSeconds);

  // Field widths
  localparam int unsigned MoistW = 7;
  localparam int unsigned WeekW  = 6;
  localparam int unsigned CountW = 6;
  localparam int unsigned RunW   = 16;
  localparam int unsigned MakeW  = CountW + RunW;
  localparam int unsigned CfgW   = 16;

  localparam logic [MoistW-1:0] MOIST_CAP    = 7'd100;
  localparam logic [MoistW-1:0] MOIST_MANUAL = 7'd30;
  localparam logic [CountW-1:0] COUNT_MAX    = 6'd63;

endpackage

FILE: rtl/core/moisture_irrigation_scheduler_core.sv
`timescale 1ns / 1ps
// The result is valid in the output register in the cycle after the input transfer.
// Throughput: one item per cycle while results are taken; the next item is taken in the cycle its
// predecessor's result transfers, set by the single result register.
// Reset (rst_ni low, asynchronous): all schedule state clears to zero, the
// registers return to threshold 50, run 315, minimum 1, maximum 5.
module moisture_irrigation_scheduler_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [mis_pkg::CfgW-1:0]    cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  command_i,
  input  logic [mis_pkg::MoistW-1:0]  moisture_i,
  input  logic [mis_pkg::WeekW-1:0]   week_number_i,
  input  logic                        week_start_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        pump_on_o,
  output logic                        sensor_supply_o,
  output logic                        watering_o,
  output logic [mis_pkg::CountW-1:0]  week_count_o,
  output logic                        started_run_o,
  output logic                        started_makeup_o
);
  import mis_pkg::*;

  // Configuration registers
  logic [MoistW-1:0] thr_q;
  logic [RunW-1:0]   run_len_q;
  logic [CountW-1:0] wmin_q, wmax_q;

  // Schedule state
  logic [WeekW-1:0]  week_q, week_d;
  logic [CountW-1:0] count_q, count_d;
  logic              run_q, run_d, pump_q, pump_d, sens_q, sens_d;
  logic              ever_q, ever_d, make_q, make_d;
  logic [WaitW-1:0]  wait_q, wait_d;
  logic [CheckW-1:0] check_q, check_d;
  logic [LockW-1:0]  water_q, water_d;
  logic [RunW-1:0]   rtim_q, rtim_d;
  logic [MakeW-1:0]  mtim_q, mtim_d;
  logic [PhaseW-1:0] phase_q, phase_d;

  // Result register
  logic              ovalid_q;
  logic              st_run_d, st_make_d;
  logic [MoistW-1:0] moist_sat;
  logic [CountW-1:0] deficit;
  logic [MakeW-1:0]  make_len;
  logic              in_xfer;

  assign in_ready_o = ~ovalid_q | out_ready_i;
  assign in_xfer    = in_valid_i & in_ready_o;
  assign moist_sat  = (moisture_i > MOIST_CAP) ? MOIST_CAP : moisture_i;

  // Compute next schedule state for one item
  always_comb begin
    week_d    = week_q;
    count_d   = count_q;
    run_d     = run_q;
    pump_d    = pump_q;
    sens_d    = sens_q;
    ever_d    = ever_q;
    make_d    = make_q;
    wait_d    = wait_q;
    check_d   = check_q;
    water_d   = water_q;
    rtim_d    = rtim_q;
    mtim_d    = mtim_q;
    phase_d   = phase_q;
    st_run_d  = 1'b0;
    st_make_d = 1'b0;
    deficit   = wmin_q - count_q;
    make_len  = '0;
    case (mis_cmd_e'(command_i))
      CMD_TICK: begin
        // Count down the runs
        if (run_q) begin
          if (rtim_q <= RunW'(1)) begin
            rtim_d = '0;
            run_d  = 1'b0;
            pump_d = 1'b0;
          end else begin
            rtim_d = rtim_q - RunW'(1);
          end
        end
        if (make_q) begin
          if (mtim_q <= MakeW'(1)) begin
            mtim_d = '0;
            make_d = 1'b0;
            pump_d = 1'b0;
          end else begin
            mtim_d = mtim_q - MakeW'(1);
          end
        end
        // Sensor delay, then read and decide
        if (sens_q) begin
          if (wait_q <= WaitW'(1)) begin
            wait_d = '0;
            sens_d = 1'b0;
            if ((moist_sat < thr_q) && (!ever_q || water_q >= LOCK_END) &&
                (count_q < wmax_q) && !run_d) begin
              st_run_d = 1'b1;
              run_d    = 1'b1;
              pump_d   = 1'b1;
              ever_d   = 1'b1;
              rtim_d   = run_len_q;
              water_d  = '0;
              if (count_q < COUNT_MAX) count_d = count_q + CountW'(1);
            end
          end else begin
            wait_d = wait_q - WaitW'(1);
          end
        end
        // Week rollover with makeup watering
        deficit = wmin_q - count_d;
        if (week_start_i && week_number_i != week_q) begin
          week_d = week_number_i;
          if (count_d < wmin_q) begin
            make_len  = MakeW'(deficit) * MakeW'(run_len_q);
            mtim_d    = make_len;
            make_d    = 1'b1;
            pump_d    = 1'b1;
            st_make_d = 1'b1;
          end
          count_d = '0;
        end
        // Advance seconds
        if (phase_q >= PHASE_LAST) begin
          phase_d = '0;
          if (water_d < LOCK_END) water_d = water_d + LockW'(1);
          if (check_q + CheckW'(1) >= CHECK_END) begin
            check_d = '0;
            sens_d  = 1'b1;
            wait_d  = WAIT_LOAD;
          end else begin
            check_d = check_q + CheckW'(1);
          end
        end else begin
          phase_d = phase_q + PhaseW'(1);
        end
      end
      CMD_MANUAL: begin
        if ((MOIST_MANUAL < thr_q) && (count_q < wmax_q) && !run_q) begin
          st_run_d = 1'b1;
          run_d    = 1'b1;
          pump_d   = 1'b1;
          ever_d   = 1'b1;
          rtim_d   = run_len_q;
          water_d  = '0;
          if (count_q < COUNT_MAX) count_d = count_q + CountW'(1);
        end
      end
      CMD_CLEAR: begin
        count_d = '0;
      end
      default: begin
      end
    endcase
  end

  // Hold configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= 7'd50;
      run_len_q <= 16'd315;
      wmin_q    <= 6'd1;
      wmax_q    <= 6'd5;
    end else if (cfg_we_i) begin
      case (mis_reg_e'(cfg_index_i))
        REG_THRESHOLD:  thr_q     <= cfg_wdata_i[MoistW-1:0];
        REG_RUN_TENTHS: run_len_q <= cfg_wdata_i[RunW-1:0];
        REG_WEEK_MIN:   wmin_q    <= cfg_wdata_i[CountW-1:0];
        REG_WEEK_MAX:   wmax_q    <= cfg_wdata_i[CountW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Update state on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      week_q  <= '0;
      count_q <= '0;
      run_q   <= 1'b0;
      pump_q  <= 1'b0;
      sens_q  <= 1'b0;
      ever_q  <= 1'b0;
      make_q  <= 1'b0;
      wait_q  <= '0;
      check_q <= '0;
      water_q <= '0;
      rtim_q  <= '0;
      mtim_q  <= '0;
      phase_q <= '0;
    end else if (in_xfer) begin
      week_q  <= week_d;
      count_q <= count_d;
      run_q   <= run_d;
      pump_q  <= pump_d;
      sens_q  <= sens_d;
      ever_q  <= ever_d;
      make_q  <= make_d;
      wait_q  <= wait_d;
      check_q <= check_d;
      water_q <= water_d;
      rtim_q  <= rtim_d;
      mtim_q  <= mtim_d;
      phase_q <= phase_d;
    end
  end

  // Result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (in_xfer) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  // Load result payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      pump_on_o        <= pump_d;
      sensor_supply_o  <= sens_d;
      watering_o       <= run_d;
      week_count_o     <= count_d;
      started_run_o    <= st_run_d;
      started_makeup_o <= st_make_d;
    end
  end

  assign out_valid_o = ovalid_q;

  // A new item never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while result stalled");

  // A started normal run shows the pump on and the run active
  a_run_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && started_run_o) |-> (pump_on_o && watering_o))
    else $error("normal start without pump and run");

  // A makeup start drives the pump and clears the weekly count
  a_makeup_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && started_makeup_o) |-> (pump_on_o && week_count_o == '0))
    else $error("makeup start inconsistent");

endmodule

FILE: bench/moisture_irrigation_scheduler_core_test.sv
`timescale 1ns / 1ps
module moisture_irrigation_scheduler_core_test;
  import mis_pkg::*;

  localparam int unsigned CycleLimit = 3_000_000;
  localparam int unsigned LongHold   = 300;
  localparam int unsigned MaxShown   = 200;

  typedef enum int {
    SINK_OPEN,
    SINK_LIGHT,
    SINK_HEAVY,
    SINK_PATTERN
  } sink_mode_e;

  typedef struct packed {
    logic              pump_on;
    logic              sensor_supply;
    logic              watering;
    logic [CountW-1:0] week_count;
    logic              started_run;
    logic              started_makeup;
  } sched_out_t;

  // Irrigation schedule tracker: own copy of registers and schedule state, plus
  // the queue of outputs owed by the block.
  class irrigation_tracker;
    logic [MoistW-1:0] thresh;
    logic [RunW-1:0]   run_len;
    logic [CountW-1:0] week_min;
    logic [CountW-1:0] week_max;

    logic [WeekW-1:0]  stored_week;
    logic [CountW-1:0] week_cnt;
    bit                run_on;
    bit                pump;
    bit                sensor_on;
    bit                watered_once;
    bit                makeup_on;
    logic [4:0]        sensor_wait;
    logic [17:0]       since_check;
    logic [17:0]       since_water;
    logic [RunW-1:0]   run_left;
    logic [MakeW-1:0]  makeup_left;
    logic [3:0]        phase;

    sched_out_t        pending[$];
    int                errors;
    int                shown;

    function new();
      thresh       = 7'd50;
      run_len      = 16'd315;
      week_min     = 6'd1;
      week_max     = 6'd5;
      stored_week  = '0;
      week_cnt     = '0;
      run_on       = 1'b0;
      pump         = 1'b0;
      sensor_on    = 1'b0;
      watered_once = 1'b0;
      makeup_on    = 1'b0;
      sensor_wait  = '0;
      since_check  = '0;
      since_water  = '0;
      run_left     = '0;
      makeup_left  = '0;
      phase        = '0;
      errors       = 0;
      shown        = 0;
    endfunction

    function void set_reg(mis_reg_e idx, logic [CfgW-1:0] val);
      case (idx)
        REG_THRESHOLD:  thresh = val[MoistW-1:0];
        REG_RUN_TENTHS: run_len = val[RunW-1:0];
        REG_WEEK_MIN:   week_min = val[CountW-1:0];
        REG_WEEK_MAX:   week_max = val[CountW-1:0];
        default: ;
      endcase
    endfunction

    function bit watering_allowed(logic [MoistW-1:0] level, bit skip_lock);
      if (level >= thresh) return 1'b0;
      if (!skip_lock && watered_once && since_water < LockSeconds) return 1'b0;
      if (week_cnt >= week_max) return 1'b0;
      return 1'b1;
    endfunction

    // A normal start is dropped while a normal run is still timing
    function bit start_run();
      if (run_on) return 1'b0;
      run_on = 1'b1;
      if (week_cnt < COUNT_MAX) week_cnt++;
      since_water  = '0;
      watered_once = 1'b1;
      pump         = 1'b1;
      run_left     = run_len;
      return 1'b1;
    endfunction

    // Advance the schedule by one accepted item and queue the owed outputs
    function void take_item(mis_cmd_e cmd, logic [MoistW-1:0] moist,
                            logic [WeekW-1:0] week, logic wstart);
      logic [MoistW-1:0] level;
      logic [CountW-1:0] deficit;
      sched_out_t        res;
      res   = '0;
      level = (moist > MOIST_CAP) ? MOIST_CAP : moist;
      case (cmd)
        CMD_TICK: begin
          // Either run ending drops the shared pump line
          if (run_on) begin
            if (run_left <= 1) begin
              run_left = '0;
              run_on   = 1'b0;
              pump     = 1'b0;
            end else begin
              run_left--;
            end
          end
          if (makeup_on) begin
            if (makeup_left <= 1) begin
              makeup_left = '0;
              makeup_on   = 1'b0;
              pump        = 1'b0;
            end else begin
              makeup_left--;
            end
          end
          // Read the sensor when its settling delay runs out
          if (sensor_on) begin
            if (sensor_wait <= 1) begin
              sensor_wait = '0;
              if (watering_allowed(level, 1'b0)) res.started_run = start_run();
              sensor_on = 1'b0;
            end else begin
              sensor_wait--;
            end
          end
          // New week: make up the shortfall, then clear the count
          if (wstart && week != stored_week) begin
            stored_week = week;
            if (week_cnt < week_min) begin
              deficit            = week_min - week_cnt;
              makeup_left        = MakeW'(deficit) * MakeW'(run_len);
              makeup_on          = 1'b1;
              pump               = 1'b1;
              res.started_makeup = 1'b1;
            end
            week_cnt = '0;
          end
          // Seconds bookkeeping on the last tick of each second
          phase++;
          if (phase >= TicksPerSecond) begin
            phase = '0;
            if (since_water < LockSeconds) since_water++;
            if (since_check < CheckPeriodS) since_check++;
            if (since_check >= CheckPeriodS) begin
              since_check = '0;
              sensor_on   = 1'b1;
              sensor_wait = 5'(SensorDelayS * TicksPerSecond);
            end
          end
        end
        CMD_MANUAL: begin
          if (watering_allowed(MOIST_MANUAL, 1'b1)) res.started_run = start_run();
        end
        CMD_CLEAR: week_cnt = '0;
        default: ;
      endcase
      res.pump_on       = pump;
      res.sensor_supply = sensor_on;
      res.watering      = run_on;
      res.week_count    = week_cnt;
      pending.push_back(res);
    endfunction

    function void check_field(string name, logic [5:0] want, logic [5:0] got);
      if (want !== got) begin
        errors++;
        if (shown < MaxShown) begin
          shown++;
          $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
      end
    endfunction

    // Compare one transferred result with the oldest owed one
    function void check_result(sched_out_t got);
      sched_out_t want;
      if (pending.size() == 0) begin
        errors++;
        if (shown < MaxShown) begin
          shown++;
          $display("%0t: result transfer with nothing owed, got %h", $time, got);
        end
        return;
      end
      want = pending.pop_front();
      check_field("pump_on", want.pump_on, got.pump_on);
      check_field("sensor_supply", want.sensor_supply, got.sensor_supply);
      check_field("watering", want.watering, got.watering);
      check_field("week_count", want.week_count, got.week_count);
      check_field("started_run", want.started_run, got.started_run);
      check_field("started_makeup", want.started_makeup, got.started_makeup);
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [1:0]        cfg_index_i;
  logic [CfgW-1:0]   cfg_wdata_i;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [1:0]        command_i;
  logic [MoistW-1:0] moisture_i;
  logic [WeekW-1:0]  week_number_i;
  logic              week_start_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic              pump_on_o;
  logic              sensor_supply_o;
  logic              watering_o;
  logic [CountW-1:0] week_count_o;
  logic              started_run_o;
  logic              started_makeup_o;

  irrigation_tracker tracker;
  sink_mode_e        sink_mode = SINK_OPEN;
  logic              hold_request = 1'b0;
  logic [WeekW-1:0]  cur_week = '0;

  moisture_irrigation_scheduler_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .command_i        (command_i),
    .moisture_i       (moisture_i),
    .week_number_i    (week_number_i),
    .week_start_i     (week_start_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .pump_on_o        (pump_on_o),
    .sensor_supply_o  (sensor_supply_o),
    .watering_o       (watering_o),
    .week_count_o     (week_count_o),
    .started_run_o    (started_run_o),
    .started_makeup_o (started_makeup_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Offer one item from a falling edge and hold it until its transfer
  task automatic drive_item(mis_cmd_e cmd, logic [MoistW-1:0] moist,
                            logic [WeekW-1:0] week, logic wstart);
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    moisture_i    <= moist;
    week_number_i <= week;
    week_start_i  <= wstart;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.take_item(cmd, moist, week, wstart);
  endtask

  task automatic idle_for(int cycles);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // Stop offering and wait until every owed result has transferred
  task automatic wait_drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (tracker.pending.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(mis_reg_e idx, logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    tracker.set_reg(idx, val);
  endtask

  task automatic write_regs(logic [MoistW-1:0] th, logic [RunW-1:0] rl,
                            logic [CountW-1:0] mn, logic [CountW-1:0] mx);
    write_reg(REG_THRESHOLD, CfgW'(th));
    write_reg(REG_RUN_TENTHS, CfgW'(rl));
    write_reg(REG_WEEK_MIN, CfgW'(mn));
    write_reg(REG_WEEK_MAX, CfgW'(mx));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mixed items in bursts with random gaps
  task automatic run_segment(int count, bit manual_ok, bit low_moist);
    int                left;
    int                burst;
    int                pick;
    mis_cmd_e          cmd;
    logic [MoistW-1:0] moist;
    logic [WeekW-1:0]  week;
    logic              wstart;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && left > 0; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 62) cmd = CMD_TICK;
        else if (pick < 82) cmd = manual_ok ? CMD_MANUAL : CMD_TICK;
        else if (pick < 94) cmd = CMD_CLEAR;
        else cmd = CMD_UNUSED;
        moist  = low_moist ? MoistW'($urandom_range(0, 40)) : MoistW'($urandom);
        wstart = ($urandom_range(0, 9) == 0);
        if (wstart && $urandom_range(0, 2) == 0) cur_week = WeekW'($urandom);
        week = ($urandom_range(0, 4) == 0) ? WeekW'($urandom) : cur_week;
        drive_item(cmd, moist, week, wstart);
        left--;
      end
      if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 8));
    end
  endtask

  // Result side: its own stall pattern, plus a long hold when requested
  initial begin : result_sink
    int hold_left;
    int beat;
    hold_left   = 0;
    beat        = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      beat++;
      if (hold_request) begin
        hold_left    = LongHold;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        case (sink_mode)
          SINK_LIGHT:   out_ready_i <= ($urandom_range(0, 9) < 7);
          SINK_HEAVY:   out_ready_i <= ($urandom_range(0, 9) < 3);
          SINK_PATTERN: out_ready_i <= ((beat % 7) >= 3);
          default:      out_ready_i <= 1'b1;
        endcase
      end
    end
  end

  // Check each result transfer, sampled before the edge updates the block
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      tracker.check_result({pump_on_o, sensor_supply_o, watering_o, week_count_o,
                            started_run_o, started_makeup_o});
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("moisture_irrigation_scheduler_core verification failed");
    $finish;
  end

  initial begin : stimulus
    int random_left;
    int seg;
    tracker       = new();
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = REG_THRESHOLD;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    command_i     = CMD_TICK;
    moisture_i    = '0;
    week_number_i = '0;
    week_start_i  = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset registers: week change with a shortfall, manual start and refusal
    drive_item(CMD_TICK, 7'd127, 6'd63, 1'b1);
    drive_item(CMD_MANUAL, 7'd0, 6'd0, 1'b0);
    drive_item(CMD_MANUAL, 7'd100, 6'd0, 1'b1);
    drive_item(CMD_TICK, 7'd101, 6'd63, 1'b1);
    drive_item(CMD_CLEAR, 7'd0, 6'd5, 1'b0);
    drive_item(CMD_UNUSED, 7'd127, 6'd63, 1'b1);
    drive_item(CMD_TICK, 7'd50, 6'd1, 1'b0);
    drive_item(CMD_TICK, 7'd0, 6'd1, 1'b1);

    // Threshold above 100 and a zero run length
    wait_drain();
    write_regs(7'd127, 16'd0, 6'd63, 6'd63);
    drive_item(CMD_MANUAL, 7'd64, 6'd1, 1'b0);
    drive_item(CMD_TICK, 7'd100, 6'd1, 1'b0);
    drive_item(CMD_MANUAL, 7'd99, 6'd1, 1'b0);
    drive_item(CMD_TICK, 7'd1, 6'd1, 1'b0);
    drive_item(CMD_TICK, 7'd2, 6'd2, 1'b1);
    drive_item(CMD_TICK, 7'd3, 6'd2, 1'b0);

    // Normal run ends while a makeup run is still timing; weekly maximum
    wait_drain();
    write_regs(7'd100, 16'd3, 6'd2, 6'd1);
    drive_item(CMD_TICK, 7'd10, 6'd3, 1'b1);
    drive_item(CMD_MANUAL, 7'd10, 6'd3, 1'b0);
    drive_item(CMD_MANUAL, 7'd10, 6'd3, 1'b0);
    repeat (3) drive_item(CMD_TICK, 7'd10, 6'd3, 1'b0);
    drive_item(CMD_MANUAL, 7'd10, 6'd3, 1'b0);
    repeat (3) drive_item(CMD_TICK, 7'd10, 6'd3, 1'b0);

    // Low extremes of the registers
    wait_drain();
    write_regs(7'd0, 16'hFFFF, 6'd0, 6'd0);
    drive_item(CMD_MANUAL, 7'd0, 6'd3, 1'b0);
    drive_item(CMD_TICK, 7'd0, 6'd0, 1'b1);

    // Climb the weekly count up to its top
    wait_drain();
    write_regs(7'd127, 16'd1, 6'd63, 6'd63);
    sink_mode = SINK_LIGHT;
    repeat (70) begin
      drive_item(CMD_MANUAL, MoistW'($urandom), cur_week, 1'b0);
      drive_item(CMD_TICK, MoistW'($urandom), cur_week, 1'b0);
    end

    // Hold off results while items keep coming, so the input stalls
    wait_drain();
    hold_request = 1'b1;
    run_segment(60, 1'b1, 1'b0);

    // Random register settings, each phase starting from an idle block
    random_left = 850;
    while (random_left > 0) begin
      wait_drain();
      write_regs(($urandom_range(0, 3) == 0) ? MoistW'($urandom)
                                              : MoistW'($urandom_range(20, 100)),
                 ($urandom_range(0, 9) == 0) ? RunW'($urandom)
                                              : RunW'($urandom_range(1, 40)),
                 CountW'($urandom_range(0, 8)), CountW'($urandom));
      sink_mode = sink_mode_e'($urandom_range(0, 3));
      seg = $urandom_range(40, 120);
      run_segment(seg, $urandom_range(0, 4) != 0, $urandom_range(0, 2) == 0);
      random_left -= seg;
    end

    // High thresholds with mixed traffic, each phase from an idle block
    for (int p = 0; p < 4; p++) begin
      wait_drain();
      write_regs(MoistW'($urandom_range(60, 127)), RunW'($urandom_range(1, 30)),
                 CountW'($urandom_range(0, 4)), (p == 3) ? CountW'($urandom) : 6'd63);
      sink_mode = sink_mode_e'($urandom_range(0, 3));
      run_segment(80, p[0], !p[0]);
    end

    wait_drain();
    repeat (10) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("moisture_irrigation_scheduler_core verification clean");
    end else begin
      $display("moisture_irrigation_scheduler_core verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/mis_pkg.sv
rtl/core/moisture_irrigation_scheduler_core.sv
bench/moisture_irrigation_scheduler_core_test.sv
